@@ rtl/utft_pkg.sv @@
// Shared constants, types and tables for the uptime to FAT timestamp core.
`timescale 1ns / 1ps

package utft_pkg;

  localparam int MsW      = 32;
  localparam int FatW     = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  // Edges from an accepted request to its result strobe.
  localparam int Latency = 14;

  typedef enum logic [CfgIdxW-1:0] {
    CfgYear   = 3'd0,
    CfgMonth  = 3'd1,
    CfgDay    = 3'd2,
    CfgHour   = 3'd3,
    CfgMinute = 3'd4,
    CfgSecond = 3'd5
  } cfg_idx_e;

  localparam logic [11:0] ResetYear   = 12'd1980;
  localparam logic [3:0]  ResetMonth  = 4'd1;
  localparam logic [4:0]  ResetDay    = 5'd1;
  localparam logic [4:0]  ResetHour   = 5'd0;
  localparam logic [5:0]  ResetMinute = 6'd0;
  localparam logic [5:0]  ResetSecond = 6'd0;

  localparam int unsigned EraDays  = 146097;
  localparam int unsigned EraYears = 400;
  localparam int unsigned FatEpoch = 1980;
  // One era is added to keep day counts positive; removed again in the year field.
  localparam int unsigned YearBias = (FatEpoch + EraYears) % 128;

  // Reciprocals: floor(x / D) = (x * ceil(2^Sh / D)) >> Sh for the x ranges used.
  localparam int Div125Sh = 36;
  localparam logic [29:0] Div125Mul = 30'(((64'd1 << Div125Sh) + 64'd124) / 64'd125);
  localparam int Div675Sh = 26;
  localparam logic [16:0] Div675Mul = 17'(((64'd1 << Div675Sh) + 64'd674) / 64'd675);
  localparam int Div225Sh = 21;
  localparam logic [13:0] Div225Mul = 14'(((64'd1 << Div225Sh) + 64'd224) / 64'd225);
  localparam int Div15Sh = 14;
  localparam logic [10:0] Div15Mul = 11'(((64'd1 << Div15Sh) + 64'd14) / 64'd15);
  localparam int Div25Sh = 14;
  localparam logic [9:0] Div25Mul = 10'(((64'd1 << Div25Sh) + 64'd24) / 64'd25);
  localparam int EraSh = 39;
  localparam logic [21:0] EraMul = 22'(((64'd1 << EraSh) + 64'd146096) / 64'd146097);
  localparam int Div365aSh = 25;
  localparam logic [16:0] Div365aMul = 17'(((64'd1 << Div365aSh) + 64'd364) / 64'd365);
  localparam int Div365bSh = 27;
  localparam logic [18:0] Div365bMul = 19'(((64'd1 << Div365bSh) + 64'd364) / 64'd365);

  typedef struct packed {
    logic [4:0] hh;
    logic [5:0] mi;
    logic [5:0] ss;
  } tod_t;

  // Day of a March-based year on which month mp starts.
  function automatic logic [8:0] month_off(input logic [3:0] mp);
    logic [8:0] off;
    case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      4'd12:   off = 9'd367;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

@@ rtl/uptime_to_fat_timestamp_core.sv @@
// Pipelined conversion of a millisecond uptime into a packed FAT date-time word.
//
// Channel   Direction  Ports                                   Handshake
// request   in         start_i, uptime_ms_i                    start_i & !busy_o
// result    out        valid_o, fat_datetime_o                 valid_o, one cycle
// config    in         cfg_we_i, cfg_idx_i, cfg_wdata_i         cfg_we_i
//
// Fourteen register stages; a request enters every cycle and its result leaves
// the last stage with valid_o. The depth comes from the chain of reciprocal
// multiplies (ms to s, s to days, days to era, year of era), each in its own stage.
// busy_o stays low: the pipeline never holds, and results cannot be held off.
// Reset clears the valid bits and sets the base moment to 1980-01-01 00:00:00.
`timescale 1ns / 1ps

module uptime_to_fat_timestamp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [utft_pkg::MsW-1:0]      uptime_ms_i,
  output logic                          valid_o,
  output logic [utft_pkg::FatW-1:0]     fat_datetime_o,
  input  logic                          cfg_we_i,
  input  logic [utft_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [utft_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import utft_pkg::*;

  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;

  logic               accept;
  logic [Latency-1:0] vld_q;
  logic [Latency-1:0] vld_d;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign vld_d  = {vld_q[Latency-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q   <= ResetYear;
      month_q  <= ResetMonth;
      day_q    <= ResetDay;
      hour_q   <= ResetHour;
      minute_q <= ResetMinute;
      second_q <= ResetSecond;
      vld_q    <= '0;
    end else begin
      vld_q <= vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgYear:   year_q   <= cfg_wdata_i[11:0];
          CfgMonth:  month_q  <= cfg_wdata_i[3:0];
          CfgDay:    day_q    <= cfg_wdata_i[4:0];
          CfgHour:   hour_q   <= cfg_wdata_i[4:0];
          CfgMinute: minute_q <= cfg_wdata_i[5:0];
          CfgSecond: second_q <= cfg_wdata_i[5:0];
          default: ;
        endcase
      end
    end
  end

  // Stage 1: ms / 1000 product; base year shift, day of year, time of day.
  logic [3:0]  base_mp;
  logic [58:0] s1_msprod_d, s1_msprod_q;
  logic [12:0] s1_yq_d, s1_yq_q;
  logic [8:0]  s1_dayoff_d, s1_dayoff_q;
  logic [16:0] s1_todb_d, s1_todb_q;

  assign base_mp     = (month_q > 4'd2) ? month_q - 4'd3 : month_q + 4'd9;
  assign s1_msprod_d = 59'(uptime_ms_i[MsW-1:3]) * 59'(Div125Mul);
  assign s1_yq_d     = 13'(year_q) + 13'(EraYears) - 13'(month_q <= 4'd2);
  assign s1_dayoff_d = month_off(base_mp) + 9'(day_q);
  assign s1_todb_d   = 17'(hour_q) * 17'd3600 + 17'(minute_q) * 17'd60 + 17'(second_q);

  // Stage 2: elapsed plus base seconds of day; base era.
  logic [22:0] s2_t_d, s2_t_q;
  logic [18:0] era1_prod;
  logic [3:0]  s2_era1_d, s2_era1_q;
  logic [12:0] s2_yq_q;
  logic [8:0]  s2_dayoff_q;

  assign s2_t_d    = s1_msprod_q[Div125Sh +: 23] + 23'(s1_todb_q);
  assign era1_prod = 19'(s1_yq_q[12:4]) * 19'(Div25Mul);
  assign s2_era1_d = era1_prod[Div25Sh +: 4];

  // Stage 3: seconds / 86400 product; base year of era.
  logic [32:0] s3_dprod_d, s3_dprod_q;
  logic [22:0] s3_t_q;
  logic [8:0]  s3_yoeb_d, s3_yoeb_q;
  logic [3:0]  s3_era1_q;
  logic [8:0]  s3_dayoff_q;

  assign s3_dprod_d = 33'(s2_t_q[22:7]) * 33'(Div675Mul);
  assign s3_yoeb_d  = 9'(s2_yq_q - 13'(s2_era1_q) * 13'(EraYears));

  // Stage 4: whole days and second of day; base day count.
  logic [5:0]  s4_qd_d, s4_qd_q;
  logic [16:0] s4_tod_d, s4_tod_q;
  logic [16:0] c100b_prod;
  logic [1:0]  s4_c100b_d, s4_c100b_q;
  logic [20:0] s4_zpart_d, s4_zpart_q;

  assign s4_qd_d    = s3_dprod_q[Div675Sh +: 6];
  assign s4_tod_d   = 17'(s3_t_q - 23'(s4_qd_d) * 23'd86400);
  assign c100b_prod = 17'(s3_yoeb_q[8:2]) * 17'(Div25Mul);
  assign s4_c100b_d = c100b_prod[Div25Sh +: 2];
  assign s4_zpart_d = 21'(s3_era1_q) * 21'(EraDays) + 21'(s3_yoeb_q) * 21'd365
                    + 21'(s3_yoeb_q[8:2]) + 21'(s3_dayoff_q) - 21'd1;

  // Stage 5: shifted day number; hour product.
  logic [20:0] s5_zp_d, s5_zp_q;
  logic [26:0] s5_hprod_d, s5_hprod_q;
  logic [16:0] s5_tod_q;

  assign s5_zp_d    = s4_zpart_q + 21'(s4_qd_q) - 21'(s4_c100b_q);
  assign s5_hprod_d = 27'(s4_tod_q[16:4]) * 27'(Div225Mul);

  // Stage 6: era product; hour and second of hour.
  logic [42:0] s6_eprod_d, s6_eprod_q;
  logic [20:0] s6_zp_q;
  logic [4:0]  s6_hh_d, s6_hh_q;
  logic [11:0] s6_r_d, s6_r_q;

  assign s6_eprod_d = 43'(s5_zp_q) * 43'(EraMul);
  assign s6_hh_d    = s5_hprod_q[Div225Sh +: 5];
  assign s6_r_d     = 12'(s5_tod_q - 17'(s6_hh_d) * 17'd3600);

  // Stage 7: era and day of era; minute product.
  logic [3:0]  s7_eraz_d, s7_eraz_q;
  logic [17:0] s7_doe_d, s7_doe_q;
  logic [20:0] s7_mprod_d, s7_mprod_q;
  logic [4:0]  s7_hh_q;
  logic [11:0] s7_r_q;

  assign s7_eraz_d  = s6_eprod_q[EraSh +: 4];
  assign s7_doe_d   = 18'(s6_zp_q - 21'(s7_eraz_d) * 21'(EraDays));
  assign s7_mprod_d = 21'(s6_r_q[11:2]) * 21'(Div15Mul);

  // Stage 8: leap corrections of day of era; minute and second.
  logic [32:0] s8_aprod_d, s8_aprod_q;
  logic [2:0]  s8_c36_d, s8_c36_q;
  logic        s8_cend_d, s8_cend_q;
  logic [17:0] s8_doe_q;
  logic [3:0]  s8_eraz_q;
  tod_t        s8_tod_d, s8_tod_q;
  logic [5:0]  mi_w;

  assign s8_aprod_d = 33'(s7_doe_q[17:2]) * 33'(Div365aMul);
  assign s8_c36_d   = 3'(s7_doe_q >= 18'd36524) + 3'(s7_doe_q >= 18'd73048)
                    + 3'(s7_doe_q >= 18'd109572) + 3'(s7_doe_q >= 18'd146096);
  assign s8_cend_d  = (s7_doe_q == 18'd146096);
  assign mi_w       = s7_mprod_q[Div15Sh +: 6];
  assign s8_tod_d   = '{hh: s7_hh_q, mi: mi_w, ss: 6'(s7_r_q - 12'(mi_w) * 12'd60)};

  // Stage 9: day of era with leap days taken out.
  logic [17:0] s9_num_d, s9_num_q;
  logic [17:0] s9_doe_q;
  logic [3:0]  s9_eraz_q;
  tod_t        s9_tod_q;

  assign s9_num_d = s8_doe_q - 18'(s8_aprod_q[Div365aSh +: 8]) + 18'(s8_c36_q)
                  - 18'(s8_cend_q);

  // Stage 10: year of era product.
  logic [36:0] s10_yprod_d, s10_yprod_q;
  logic [17:0] s10_doe_q;
  logic [3:0]  s10_eraz_q;
  tod_t        s10_tod_q;

  assign s10_yprod_d = 37'(s9_num_q) * 37'(Div365bMul);

  // Stage 11: year of era and its century count.
  logic [8:0]  s11_yoe_d, s11_yoe_q;
  logic [16:0] c100_prod;
  logic [1:0]  s11_c100_d, s11_c100_q;
  logic [17:0] s11_doe_q;
  logic [3:0]  s11_eraz_q;
  tod_t        s11_tod_q;

  assign s11_yoe_d  = s10_yprod_q[Div365bSh +: 9];
  assign c100_prod  = 17'(s11_yoe_d[8:2]) * 17'(Div25Mul);
  assign s11_c100_d = c100_prod[Div25Sh +: 2];

  // Stage 12: day of March-based year.
  logic [8:0] s12_doy_d, s12_doy_q;
  logic [8:0] s12_yoe_q;
  logic [3:0] s12_eraz_q;
  tod_t       s12_tod_q;

  assign s12_doy_d = 9'(s11_doe_q - (18'(s11_yoe_q) * 18'd365 + 18'(s11_yoe_q[8:2])
                   - 18'(s11_c100_q)));

  // Stage 13: month of March-based year.
  logic [3:0] s13_mp_d, s13_mp_q;
  logic [8:0] s13_doy_q;
  logic [8:0] s13_yoe_q;
  logic [3:0] s13_eraz_q;
  tod_t       s13_tod_q;

  always_comb begin
    s13_mp_d = 4'd0;
    for (int k = 1; k < 12; k++) begin
      s13_mp_d = s13_mp_d + 4'(s12_doy_q >= month_off(4'(k)));
    end
  end

  // Stage 14: pack.
  logic [4:0]      day_w;
  logic [3:0]      mon_w;
  logic [6:0]      yr_w;
  logic [FatW-1:0] fat_d, fat_q;

  assign day_w = 5'(s13_doy_q - month_off(s13_mp_q) + 9'd1);
  assign mon_w = (s13_mp_q < 4'd10) ? s13_mp_q + 4'd3 : s13_mp_q - 4'd9;
  assign yr_w  = s13_yoe_q[6:0] + {s13_eraz_q[2:0], 4'b0000} + 7'(s13_mp_q >= 4'd10)
               - 7'(YearBias);
  assign fat_d = {yr_w, mon_w, day_w, s13_tod_q.hh, s13_tod_q.mi, s13_tod_q.ss[5:1]};

  always_ff @(posedge clk_i) begin
    s1_msprod_q <= s1_msprod_d;
    s1_yq_q     <= s1_yq_d;
    s1_dayoff_q <= s1_dayoff_d;
    s1_todb_q   <= s1_todb_d;

    s2_t_q      <= s2_t_d;
    s2_era1_q   <= s2_era1_d;
    s2_yq_q     <= s1_yq_q;
    s2_dayoff_q <= s1_dayoff_q;

    s3_dprod_q  <= s3_dprod_d;
    s3_t_q      <= s2_t_q;
    s3_yoeb_q   <= s3_yoeb_d;
    s3_era1_q   <= s2_era1_q;
    s3_dayoff_q <= s2_dayoff_q;

    s4_qd_q     <= s4_qd_d;
    s4_tod_q    <= s4_tod_d;
    s4_c100b_q  <= s4_c100b_d;
    s4_zpart_q  <= s4_zpart_d;

    s5_zp_q     <= s5_zp_d;
    s5_hprod_q  <= s5_hprod_d;
    s5_tod_q    <= s4_tod_q;

    s6_eprod_q  <= s6_eprod_d;
    s6_zp_q     <= s5_zp_q;
    s6_hh_q     <= s6_hh_d;
    s6_r_q      <= s6_r_d;

    s7_eraz_q   <= s7_eraz_d;
    s7_doe_q    <= s7_doe_d;
    s7_mprod_q  <= s7_mprod_d;
    s7_hh_q     <= s6_hh_q;
    s7_r_q      <= s6_r_q;

    s8_aprod_q  <= s8_aprod_d;
    s8_c36_q    <= s8_c36_d;
    s8_cend_q   <= s8_cend_d;
    s8_doe_q    <= s7_doe_q;
    s8_eraz_q   <= s7_eraz_q;
    s8_tod_q    <= s8_tod_d;

    s9_num_q    <= s9_num_d;
    s9_doe_q    <= s8_doe_q;
    s9_eraz_q   <= s8_eraz_q;
    s9_tod_q    <= s8_tod_q;

    s10_yprod_q <= s10_yprod_d;
    s10_doe_q   <= s9_doe_q;
    s10_eraz_q  <= s9_eraz_q;
    s10_tod_q   <= s9_tod_q;

    s11_yoe_q   <= s11_yoe_d;
    s11_c100_q  <= s11_c100_d;
    s11_doe_q   <= s10_doe_q;
    s11_eraz_q  <= s10_eraz_q;
    s11_tod_q   <= s10_tod_q;

    s12_doy_q   <= s12_doy_d;
    s12_yoe_q   <= s11_yoe_q;
    s12_eraz_q  <= s11_eraz_q;
    s12_tod_q   <= s11_tod_q;

    s13_mp_q    <= s13_mp_d;
    s13_doy_q   <= s12_doy_q;
    s13_yoe_q   <= s12_yoe_q;
    s13_eraz_q  <= s12_eraz_q;
    s13_tod_q   <= s12_tod_q;

    fat_q       <= fat_d;
  end

  assign valid_o        = vld_q[Latency-1];
  assign fat_datetime_o = fat_q;

endmodule

@@ rtl/utft_checker.sv @@
// Port-level checker for the uptime to FAT timestamp core, with its bind.
`timescale 1ns / 1ps

module utft_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      valid_o,
  input logic [utft_pkg::FatW-1:0] fat_datetime_o
);
  import utft_pkg::*;

  // Every accepted request yields its result after the fixed latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency valid_o)
    else $error("request without result");

  // No result without a request the latency before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without request");

  // Calendar fields of a result are normalized.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (fat_datetime_o[24:21] != 4'd0 && fat_datetime_o[24:21] <= 4'd12
                 && fat_datetime_o[20:16] != 5'd0))
    else $error("month or day out of range");

  // Time of day fields of a result are normalized.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (fat_datetime_o[15:11] <= 5'd23 && fat_datetime_o[10:5] <= 6'd59
                 && fat_datetime_o[4:0] <= 5'd29))
    else $error("time of day out of range");

endmodule

bind uptime_to_fat_timestamp_core utft_checker u_utft_checker (.*);

@@ sim/tb.sv @@
// Testbench for the uptime to FAT timestamp core: directed table, then random requests.
`timescale 1ns / 1ps

module tb;
  import utft_pkg::*;

  localparam int HalfPeriod = 10;
  localparam int ResetCycles = 7;
  localparam int QuietLimit = 1000;
  localparam int MaxReports = 10;
  localparam int RandItems = 1850;
  localparam int Rounds = 6;
  localparam int MaxGap = 60;

  localparam longint CivilShift = 719468;
  localparam longint EraLenDays = 146097;
  localparam longint SecsPerDay = 86400;
  localparam longint FatBaseYear = 1980;
  localparam logic [31:0] MsPerSec = 32'd1000;
  localparam logic [31:0] MsPerDay = 32'd86_400_000;

  // Indexes that select no register.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } base_cfg_t;

  typedef struct packed {
    base_cfg_t   cfg;
    logic [31:0] ms;
    logic        known;
    logic [31:0] want;
  } probe_t;

  localparam base_cfg_t ResetCfg =
    '{ResetYear, ResetMonth, ResetDay, ResetHour, ResetMinute, ResetSecond};
  localparam base_cfg_t LastFatSec = '{12'd2107, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59};
  localparam base_cfg_t AllZero = '{12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0};
  localparam base_cfg_t AllOnes = '{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63};

  localparam int NumProbes = 25;
  probe_t probes [NumProbes] = '{
    '{ResetCfg, 32'd0,          1'b1, 32'h0021_0000},
    '{ResetCfg, 32'd999,        1'b1, 32'h0021_0000},
    '{ResetCfg, 32'd2000,       1'b1, 32'h0021_0001},
    '{ResetCfg, 32'd59999,      1'b1, 32'h0021_001D},
    '{ResetCfg, 32'd60000,      1'b1, 32'h0021_0020},
    '{ResetCfg, 32'd3600000,    1'b1, 32'h0021_0800},
    '{ResetCfg, 32'd86400000,   1'b1, 32'h0022_0000},
    '{ResetCfg, 32'hFFFF_FFFF,  1'b1, 32'h0053_8857},
    '{LastFatSec, 32'd0,        1'b1, 32'hFF9F_BF7D},
    '{LastFatSec, 32'd1000,     1'b1, 32'h0021_0000},
    '{LastFatSec, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{'{12'd2000, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59}, 32'd1000, 1'b0, 32'h0},
    '{'{12'd2100, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59}, 32'd1000, 1'b0, 32'h0},
    '{'{12'd1990, 4'd0, 5'd15, 5'd12, 6'd0, 6'd0}, 32'd0, 1'b0, 32'h0},
    '{'{12'd1990, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0}, 32'd0, 1'b0, 32'h0},
    '{'{12'd1990, 4'd15, 5'd31, 5'd0, 6'd0, 6'd0}, 32'd5000, 1'b0, 32'h0},
    '{'{12'd1990, 4'd3, 5'd0, 5'd0, 6'd0, 6'd0}, 32'd0, 1'b0, 32'h0},
    '{'{12'd1990, 4'd2, 5'd31, 5'd0, 6'd0, 6'd0}, 32'd0, 1'b0, 32'h0},
    '{'{12'd1990, 4'd6, 5'd10, 5'd31, 6'd63, 6'd63}, 32'd0, 1'b0, 32'h0},
    '{'{12'd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd0}, 32'd30000, 1'b0, 32'h0},
    '{AllZero, 32'd0,           1'b0, 32'h0},
    '{AllZero, 32'hFFFF_FFFF,   1'b0, 32'h0},
    '{AllOnes, 32'd0,           1'b0, 32'h0},
    '{AllOnes, 32'hFFFF_FFFF,   1'b0, 32'h0},
    '{'{12'd1600, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0}, 32'd86400000, 1'b0, 32'h0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [MsW-1:0] uptime_ms_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgYear;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic busy_o;
  logic valid_o;
  logic [FatW-1:0] fat_datetime_o;

  base_cfg_t cur_cfg = ResetCfg;
  logic [31:0] stamp_q [$];
  int errs = 0;
  int quiet = 0;
  int idle_pct = 15;
  bit req_held = 1'b0;

  uptime_to_fat_timestamp_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .uptime_ms_i    (uptime_ms_i),
    .valid_o        (valid_o),
    .fat_datetime_o (fat_datetime_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint day_index_of(longint y, longint m, longint d);
    longint era, yoe, mp, doy, doe;
    if (m <= 2) y = y - 1;
    era = floor_quot(y, 400);
    yoe = y - era * 400;
    mp = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * EraLenDays + doe - CivilShift;
  endfunction

  function automatic void date_of_day_index(input longint z, output longint y,
                                            output longint m, output longint d);
    longint era, doe, yoe, doy, mp;
    z = z + CivilShift;
    era = floor_quot(z, EraLenDays);
    doe = z - era * EraLenDays;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    d = doy - (153 * mp + 2) / 5 + 1;
    m = (mp < 10) ? mp + 3 : mp - 9;
    y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  function automatic logic [31:0] fat_of_uptime(logic [31:0] ms);
    longint base_s, now_s, days, tod, y, mo, d;
    logic [6:0] yf;
    logic [5:0] hh, mi, ss;
    base_s = day_index_of(longint'(cur_cfg.year), longint'(cur_cfg.month),
                          longint'(cur_cfg.day)) * SecsPerDay
           + longint'(cur_cfg.hour) * 3600 + longint'(cur_cfg.minute) * 60
           + longint'(cur_cfg.second);
    now_s = base_s + longint'(ms / MsPerSec);
    days = floor_quot(now_s, SecsPerDay);
    tod = now_s - days * SecsPerDay;
    date_of_day_index(days, y, mo, d);
    yf = 7'(y - FatBaseYear);  // year field wraps mod 128
    hh = 6'(tod / 3600);
    mi = 6'((tod % 3600) / 60);
    ss = 6'(tod % 60);
    return {yf, mo[3:0], d[4:0], hh[4:0], mi, ss[5:1]};
  endfunction

  function automatic logic [31:0] rand_uptime();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 300000);
      2: v = $urandom_range(0, 4294966) * MsPerSec + ($urandom_range(0, 1) ? 999 : 0);
      3: v = $urandom_range(1, 49) * MsPerDay - $urandom_range(0, 1000);
      default: v = 32'hFFFF_FFFF - $urandom_range(0, 100000);
    endcase
    return v;
  endfunction

  function automatic base_cfg_t rand_cfg(bit wild);
    base_cfg_t c;
    if (wild) begin
      c.year = 12'($urandom);
      c.month = 4'($urandom_range(0, 15));
      c.day = 5'($urandom_range(0, 31));
      c.hour = 5'($urandom_range(0, 31));
      c.minute = 6'($urandom_range(0, 63));
      c.second = 6'($urandom_range(0, 63));
    end else begin
      c.year = 12'($urandom_range(1980, 2107));
      c.month = 4'($urandom_range(1, 12));
      c.day = 5'($urandom_range(1, 28));
      c.hour = 5'($urandom_range(0, 23));
      c.minute = 6'($urandom_range(0, 59));
      c.second = 6'($urandom_range(0, 59));
    end
    return c;
  endfunction

  task automatic flag_err(input string what, input logic [31:0] want, input logic [31:0] got);
    errs++;
    if (errs <= MaxReports) begin
      $display("%0t: %s: expected %08h, got %08h", $time, what, want, got);
    end
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Upper bits beyond a register's width are junk when noisy; the block must drop them.
  task automatic load_cfg(input base_cfg_t c, input bit noisy);
    logic [CfgDataW-1:0] noise;
    noise = noisy ? CfgDataW'($urandom) : '0;
    if (noisy) put_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, noise);
    put_reg(CfgYear, c.year);
    put_reg(CfgMonth, {noise[11:4], c.month});
    put_reg(CfgDay, {noise[11:5], c.day});
    put_reg(CfgHour, {noise[11:5], c.hour});
    put_reg(CfgMinute, {noise[11:6], c.minute});
    put_reg(CfgSecond, {noise[11:6], c.second});
    cfg_we_i <= 1'b0;
    cur_cfg = c;
    @(posedge clk_i);
  endtask

  task automatic settle();
    if (req_held) begin
      start_i <= 1'b0;
      req_held = 1'b0;
      @(posedge clk_i);
    end
    while (stamp_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send(input logic [31:0] ms, input logic known, input logic [31:0] want);
    int gap;
    start_i <= 1'b1;
    uptime_ms_i <= ms;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    stamp_q.push_back(known ? want : fat_of_uptime(ms));
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct && gap < MaxGap) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      uptime_ms_i <= $urandom;
      req_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      req_held = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    if (valid_o || (start_i && !busy_o)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_ni && valid_o) begin
      if (stamp_q.size() == 0) begin
        flag_err("result with no request pending", 'x, fat_datetime_o);
      end else if (fat_datetime_o !== stamp_q[0]) begin
        flag_err("fat_datetime mismatch", stamp_q[0], fat_datetime_o);
        void'(stamp_q.pop_front());
      end else begin
        void'(stamp_q.pop_front());
      end
    end
  end

  initial begin
    int per_round;
    int phase_pct [3];
    base_cfg_t c;
    per_round = RandItems / (3 * Rounds);
    phase_pct = '{15, 84, 0};
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumProbes; i++) begin
      if (probes[i].cfg != cur_cfg) begin
        settle();
        load_cfg(probes[i].cfg, 1'b0);
      end
      send(probes[i].ms, probes[i].known, probes[i].want);
    end

    for (int p = 0; p < 3; p++) begin
      idle_pct = phase_pct[p];
      for (int r = 0; r < Rounds; r++) begin
        case (r)
          0: c = AllZero;
          1: c = AllOnes;
          default: c = rand_cfg(r >= 4);
        endcase
        settle();
        load_cfg(c, r >= 3);
        for (int n = 0; n < per_round; n++) send(rand_uptime(), 1'b0, '0);
      end
    end

    settle();
    repeat (Latency + 4) @(posedge clk_i);
    if (stamp_q.size() != 0) flag_err("requests left without result", stamp_q[0], 'x);
    if (errs == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/utft_pkg.sv
rtl/uptime_to_fat_timestamp_core.sv
rtl/utft_checker.sv
sim/tb.sv
